/* sv/jiap_pkg.sv */
// Shared types, codes and helpers for the JTAG ISP array programmer.
package jiap_pkg;

  // Default sizes handed to the top level parameters
  localparam int ARRAY_DEPTH_DEF  = 32768;
  localparam int BUFFER_BYTES_DEF = 256;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DATA_BITS     = 3'd0,
    CFG_ADDR_BITS     = 3'd1,
    CFG_BOUNDARY_BITS = 3'd2,
    CFG_ID_CODE       = 3'd3,
    CFG_ARRAY_BYTES   = 3'd4
  } jiap_cfg_idx_t;

  // Configuration reset values
  localparam logic [11:0] DATA_BITS_RST     = 12'd740;
  localparam logic [11:0] ADDR_BITS_RST     = 12'd100;
  localparam logic [11:0] BOUNDARY_BITS_RST = 12'd196;
  localparam logic [31:0] ID_CODE_RST       = 32'h0181_1043;
  localparam logic [15:0] ARRAY_BYTES_RST   = 16'd9300;

  // TAP event and buffer access commands
  typedef enum logic [2:0] {
    CMD_CAPTURE_IR = 3'd0,
    CMD_UPDATE_IR  = 3'd1,
    CMD_CAPTURE_DR = 3'd2,
    CMD_UPDATE_DR  = 3'd3,
    CMD_WRITE_BYTE = 3'd4,
    CMD_READ_BYTE  = 3'd5
  } jiap_cmd_code_t;

  // Instruction opcodes
  localparam logic [7:0] OP_ADDR_SHIFT = 8'h01;
  localparam logic [7:0] OP_ERASE      = 8'h03;
  localparam logic [7:0] OP_ENABLE     = 8'h15;
  localparam logic [7:0] OP_IDCODE     = 8'h16;
  localparam logic [7:0] OP_USERCODE   = 8'h17;
  localparam logic [7:0] OP_USER_PROG  = 8'h1A;
  localparam logic [7:0] OP_SAMPLE     = 8'h1C;
  localparam logic [7:0] OP_IR_CAPTURE = 8'h1D;
  localparam logic [7:0] OP_DISABLE    = 8'h1E;
  localparam logic [7:0] OP_ADDR_INIT  = 8'h21;
  localparam logic [7:0] OP_PROGRAM    = 8'h27;
  localparam logic [7:0] OP_READ       = 8'h2A;
  localparam logic [7:0] OP_BYPASS     = 8'hFF;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_OVERFLOW   = 3'd1,
    STS_NOT_ERASED = 3'd2,
    STS_NOT_ISP    = 3'd3,
    STS_BAD_ADDR   = 3'd4,
    STS_UNKNOWN    = 3'd5
  } jiap_status_t;

  // Controller states, also the datapath operation of the cycle
  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_ERASE, ST_LOAD, ST_STORE, ST_SEARCH,
    ST_SCALE, ST_ID_WR, ST_UC_WR, ST_UC_RD, ST_BYTE_RD, ST_DONE
  } jiap_state_t;

  // Multi-cycle work picked by the decoder
  typedef enum logic [3:0] {
    ACT_NONE, ACT_ERASE, ACT_LOAD, ACT_STORE, ACT_SEARCH,
    ACT_ID_WR, ACT_UC_WR, ACT_UC_RD, ACT_BYTE_RD
  } jiap_act_t;

  typedef struct packed {
    jiap_state_t op;
    logic        accept;
    logic        load_out;
  } jiap_cmd_t;

  typedef struct packed {
    jiap_act_t act;
    logic      done;
  } jiap_sts_t;

  // Bit reversal of one byte
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = v[7-k];
    return r;
  endfunction

endpackage

/* sv/jiap_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module jiap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* sv/jiap_ctrl.sv */
// Sequencing state machine: item handshake, operation steps, result register.
module jiap_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  jiap_pkg::jiap_sts_t sts,
  output jiap_pkg::jiap_cmd_t cmd
);

  jiap_pkg::jiap_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      jiap_pkg::ST_INIT: if (sts.done) state_nxt = jiap_pkg::ST_IDLE;
      jiap_pkg::ST_IDLE: if (in_tvalid) state_nxt = jiap_pkg::ST_DECODE;
      jiap_pkg::ST_DECODE: begin
        unique case (sts.act)
          jiap_pkg::ACT_NONE:    state_nxt = jiap_pkg::ST_DONE;
          jiap_pkg::ACT_ERASE:   state_nxt = jiap_pkg::ST_ERASE;
          jiap_pkg::ACT_LOAD:    state_nxt = jiap_pkg::ST_LOAD;
          jiap_pkg::ACT_STORE:   state_nxt = jiap_pkg::ST_STORE;
          jiap_pkg::ACT_SEARCH:  state_nxt = jiap_pkg::ST_SEARCH;
          jiap_pkg::ACT_ID_WR:   state_nxt = jiap_pkg::ST_ID_WR;
          jiap_pkg::ACT_UC_WR:   state_nxt = jiap_pkg::ST_UC_WR;
          jiap_pkg::ACT_UC_RD:   state_nxt = jiap_pkg::ST_UC_RD;
          jiap_pkg::ACT_BYTE_RD: state_nxt = jiap_pkg::ST_BYTE_RD;
          default:               state_nxt = jiap_pkg::ST_DONE;
        endcase
      end
      jiap_pkg::ST_ERASE, jiap_pkg::ST_LOAD, jiap_pkg::ST_STORE, jiap_pkg::ST_ID_WR,
      jiap_pkg::ST_UC_WR, jiap_pkg::ST_UC_RD, jiap_pkg::ST_BYTE_RD: begin
        if (sts.done) state_nxt = jiap_pkg::ST_DONE;
      end
      jiap_pkg::ST_SEARCH: if (sts.done) state_nxt = jiap_pkg::ST_SCALE;
      jiap_pkg::ST_SCALE:  state_nxt = jiap_pkg::ST_DONE;
      jiap_pkg::ST_DONE:   if (out_free) state_nxt = jiap_pkg::ST_IDLE;
      default:             state_nxt = jiap_pkg::ST_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready    = (state_r == jiap_pkg::ST_IDLE);
    cmd.op       = state_r;
    cmd.accept   = (state_r == jiap_pkg::ST_IDLE) && in_tvalid;
    cmd.load_out = (state_r == jiap_pkg::ST_DONE) && out_free;
  end

  // Result valid flag
  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jiap_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/jiap_dp.sv */
// Datapath: config, instruction and ISP state, shift buffer, fuse array, result.
module jiap_dp #(
  parameter int ARRAY_DEPTH  = jiap_pkg::ARRAY_DEPTH_DEF,
  parameter int BUFFER_BYTES = jiap_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_tuser,
  input  logic [23:0]         in_tdata,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  jiap_pkg::jiap_cmd_t cmd,
  output jiap_pkg::jiap_sts_t sts,
  output logic [23:0]         out_tdata
);

  localparam int AW  = $clog2(ARRAY_DEPTH);
  localparam int CW  = AW + 1;
  localparam int BW  = $clog2(BUFFER_BYTES);
  localparam int NW  = $clog2(BUFFER_BYTES + 1);
  localparam int PW  = BW + 3;
  localparam int RAW = (PW + NW > CW) ? PW + NW : CW;

  // Configuration
  logic [11:0] data_bits_r, data_bits_nxt;
  logic [11:0] addr_bits_r, addr_bits_nxt;
  logic [11:0] bound_bits_r, bound_bits_nxt;
  logic [31:0] id_code_r, id_code_nxt;
  logic [15:0] array_bytes_r, array_bytes_nxt;

  // Item fields
  logic [2:0] it_cmd_r, it_cmd_nxt;
  logic [7:0] it_instr_r, it_instr_nxt;
  logic [7:0] it_idx_r, it_idx_nxt;
  logic [7:0] it_val_r, it_val_nxt;

  // ISP state
  logic [7:0]     ir_r, ir_nxt;
  logic           isp_r, isp_nxt;
  logic           pp_r, pp_nxt;
  logic           rp_r, rp_nxt;
  logic [RAW-1:0] ra_r, ra_nxt;
  logic [RAW-1:0] wa_r, wa_nxt;
  logic [RAW-1:0] base_r, base_nxt;
  logic [31:0]    uc_r, uc_nxt;

  // Step sequencing
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pend_r, pend_nxt;
  logic [BW-1:0]  pidx_r, pidx_nxt;
  logic           found_r, found_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [BUFFER_BYTES-1:0] vld_r, vld_nxt;
  logic           bv_q_r, bv_q_nxt;

  // Result
  logic [7:0]  res_rd_r, res_rd_nxt;
  logic [11:0] res_len_r, res_len_nxt;
  logic [2:0]  res_st_r, res_st_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  // Memory ports
  logic          b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [7:0]    b_wdata, b_q, b_eff;
  logic          f_we;
  logic [AW-1:0] f_waddr, f_raddr;
  logic [7:0]    f_wdata, f_q;

  // Derived sizes
  logic [12:0]      dsb_p7, sl_p7;
  logic [9:0]       row_raw, srch_bytes;
  logic [NW-1:0]    row_n;
  logic [CW-1:0]    arr_size, lim;
  logic [11:0]      srch_lim;
  logic [RAW:0]     rd_end, wr_end;
  logic             ovf_rd, ovf_wr;
  logic [PW+NW-1:0] prod;
  logic [7:0]       srch_mask;
  logic [2:0]       srch_bit;
  logic             running, issue, reads;
  logic [RAW-1:0]   fuse_off;

  assign dsb_p7   = {1'b0, data_bits_r} + 13'd7;
  assign row_raw  = dsb_p7[12:3];
  assign row_n    = (32'(row_raw) > BUFFER_BYTES) ? NW'(BUFFER_BYTES) : NW'(row_raw);
  assign arr_size = (32'(array_bytes_r) > ARRAY_DEPTH) ? CW'(ARRAY_DEPTH)
                                                       : CW'(array_bytes_r);
  assign srch_lim = (32'(addr_bits_r) > BUFFER_BYTES * 8) ? 12'(BUFFER_BYTES * 8)
                                                          : addr_bits_r;
  assign sl_p7      = {1'b0, srch_lim} + 13'd7;
  assign srch_bytes = sl_p7[12:3];
  assign rd_end   = {1'b0, ra_r} + (RAW+1)'(row_n);
  assign wr_end   = {1'b0, wa_r} + (RAW+1)'(row_n);
  assign ovf_rd   = rd_end > (RAW+1)'(arr_size);
  assign ovf_wr   = wr_end > (RAW+1)'(arr_size);
  assign prod     = pos_r * row_n;
  assign b_eff    = bv_q_r ? b_q : 8'h00;
  assign fuse_off = base_r + RAW'(cnt_r);

  // First set bit of the buffer byte under search, within the address length
  always_comb begin
    srch_mask = '0;
    for (int b = 0; b < 8; b++) begin
      srch_mask[b] = b_eff[b] && (13'({pidx_r, 3'(b)}) < 13'(srch_lim));
    end
    srch_bit = '0;
    for (int b = 7; b >= 0; b--) begin
      if (srch_mask[b]) srch_bit = 3'(b);
    end
  end

  // Step count of the running operation
  always_comb begin
    running = 1'b1;
    reads   = 1'b0;
    unique case (cmd.op)
      jiap_pkg::ST_INIT:    lim = CW'(ARRAY_DEPTH);
      jiap_pkg::ST_ERASE:   lim = arr_size;
      jiap_pkg::ST_LOAD:    begin lim = CW'(row_n); reads = 1'b1; end
      jiap_pkg::ST_STORE:   begin lim = CW'(row_n); reads = 1'b1; end
      jiap_pkg::ST_SEARCH:  begin lim = CW'(srch_bytes); reads = 1'b1; end
      jiap_pkg::ST_ID_WR:   lim = CW'(4);
      jiap_pkg::ST_UC_WR:   lim = CW'(4);
      jiap_pkg::ST_UC_RD:   begin lim = CW'(4); reads = 1'b1; end
      jiap_pkg::ST_BYTE_RD: begin lim = CW'(1); reads = 1'b1; end
      default:              begin lim = '0; running = 1'b0; end
    endcase
    issue = running && (cnt_r < lim) &&
            !((cmd.op == jiap_pkg::ST_SEARCH) && found_r);
  end

  // Next values
  always_comb begin
    data_bits_nxt = data_bits_r;   addr_bits_nxt = addr_bits_r;
    bound_bits_nxt = bound_bits_r; id_code_nxt = id_code_r;
    array_bytes_nxt = array_bytes_r;
    it_cmd_nxt = it_cmd_r; it_instr_nxt = it_instr_r;
    it_idx_nxt = it_idx_r; it_val_nxt = it_val_r;
    ir_nxt = ir_r; isp_nxt = isp_r; pp_nxt = pp_r; rp_nxt = rp_r;
    ra_nxt = ra_r; wa_nxt = wa_r; base_nxt = base_r; uc_nxt = uc_r;
    cnt_nxt = cnt_r; pend_nxt = 1'b0; pidx_nxt = pidx_r;
    found_nxt = found_r; pos_nxt = pos_r; vld_nxt = vld_r;
    res_rd_nxt = res_rd_r; res_len_nxt = res_len_r; res_st_nxt = res_st_r;
    out_data_nxt = out_data_r;
    b_we = 1'b0; b_waddr = cnt_r[BW-1:0]; b_wdata = 8'h00; b_raddr = cnt_r[BW-1:0];
    f_we = 1'b0; f_waddr = cnt_r[AW-1:0]; f_wdata = 8'hFF; f_raddr = fuse_off[AW-1:0];
    sts.act = jiap_pkg::ACT_NONE;
    sts.done = ((cnt_r == lim) && !pend_r) ||
               ((cmd.op == jiap_pkg::ST_SEARCH) && found_r);

    // Configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        jiap_pkg::CFG_DATA_BITS:     data_bits_nxt = cfg_data[11:0];
        jiap_pkg::CFG_ADDR_BITS:     addr_bits_nxt = cfg_data[11:0];
        jiap_pkg::CFG_BOUNDARY_BITS: bound_bits_nxt = cfg_data[11:0];
        jiap_pkg::CFG_ID_CODE:       id_code_nxt = cfg_data;
        jiap_pkg::CFG_ARRAY_BYTES:   array_bytes_nxt = cfg_data[15:0];
        default: ;
      endcase
    end

    // Item capture
    if (cmd.accept) begin
      it_cmd_nxt   = in_tuser;
      it_instr_nxt = in_tdata[7:0];
      it_idx_nxt   = in_tdata[15:8];
      it_val_nxt   = in_tdata[23:16];
    end

    // Decode: immediate effects and choice of follow-up work
    if (cmd.op == jiap_pkg::ST_DECODE) begin
      cnt_nxt = '0; found_nxt = 1'b0;
      res_rd_nxt = 8'h00; res_len_nxt = 12'd0; res_st_nxt = jiap_pkg::STS_OK;
      unique case (it_cmd_r)
        jiap_pkg::CMD_CAPTURE_IR: begin
          ir_nxt = jiap_pkg::OP_IR_CAPTURE;
          res_rd_nxt = jiap_pkg::OP_IR_CAPTURE;
          res_len_nxt = 12'd8;
        end
        jiap_pkg::CMD_UPDATE_IR: begin
          ir_nxt = it_instr_r;
          unique case (it_instr_r)
            jiap_pkg::OP_ERASE: begin
              if (!isp_r) res_st_nxt = jiap_pkg::STS_NOT_ISP;
              else begin
                uc_nxt = '1;
                sts.act = jiap_pkg::ACT_ERASE;
              end
            end
            jiap_pkg::OP_ENABLE: begin
              isp_nxt = 1'b1; rp_nxt = 1'b0; pp_nxt = 1'b0;
            end
            jiap_pkg::OP_DISABLE:   isp_nxt = 1'b0;
            jiap_pkg::OP_ADDR_INIT: begin ra_nxt = '0; wa_nxt = '0; end
            jiap_pkg::OP_PROGRAM:   pp_nxt = 1'b1;
            jiap_pkg::OP_READ:      rp_nxt = 1'b1;
            default: ;
          endcase
        end
        jiap_pkg::CMD_CAPTURE_DR: begin
          unique case (ir_r)
            jiap_pkg::OP_ADDR_SHIFT: res_len_nxt = addr_bits_r;
            jiap_pkg::OP_IDCODE: begin
              res_len_nxt = 12'd32; sts.act = jiap_pkg::ACT_ID_WR;
            end
            jiap_pkg::OP_USER_PROG: res_len_nxt = 12'd32;
            jiap_pkg::OP_USERCODE: begin
              res_len_nxt = 12'd32; sts.act = jiap_pkg::ACT_UC_WR;
            end
            jiap_pkg::OP_SAMPLE: begin
              res_len_nxt = bound_bits_r; vld_nxt = '0;
            end
            jiap_pkg::OP_PROGRAM: begin
              res_len_nxt = data_bits_r;
              if (rp_r) begin
                rp_nxt = 1'b0;
                if (ovf_rd) res_st_nxt = jiap_pkg::STS_OVERFLOW;
                else begin
                  base_nxt = ra_r; ra_nxt = rd_end[RAW-1:0];
                  sts.act = jiap_pkg::ACT_LOAD;
                end
              end
            end
            jiap_pkg::OP_READ: begin
              res_len_nxt = data_bits_r;
              rp_nxt = 1'b0;
              if (!pp_r) begin
                if (ovf_rd) res_st_nxt = jiap_pkg::STS_OVERFLOW;
                else begin
                  base_nxt = ra_r; ra_nxt = rd_end[RAW-1:0];
                  sts.act = jiap_pkg::ACT_LOAD;
                end
              end
            end
            jiap_pkg::OP_BYPASS: res_len_nxt = 12'd1;
            default: res_st_nxt = jiap_pkg::STS_UNKNOWN;
          endcase
        end
        jiap_pkg::CMD_UPDATE_DR: begin
          unique case (ir_r)
            jiap_pkg::OP_ADDR_SHIFT: sts.act = jiap_pkg::ACT_SEARCH;
            jiap_pkg::OP_READ, jiap_pkg::OP_PROGRAM: begin
              if (!isp_r) res_st_nxt = jiap_pkg::STS_NOT_ISP;
              else if (pp_r || (ir_r == jiap_pkg::OP_PROGRAM)) begin
                pp_nxt = 1'b0;
                if (ovf_wr) res_st_nxt = jiap_pkg::STS_OVERFLOW;
                else begin
                  base_nxt = wa_r; wa_nxt = wr_end[RAW-1:0];
                  sts.act = jiap_pkg::ACT_STORE;
                end
              end
            end
            jiap_pkg::OP_USER_PROG: begin
              if (!isp_r) res_st_nxt = jiap_pkg::STS_NOT_ISP;
              else sts.act = jiap_pkg::ACT_UC_RD;
            end
            default: ;
          endcase
        end
        jiap_pkg::CMD_WRITE_BYTE: begin
          if (32'(it_idx_r) < BUFFER_BYTES) begin
            b_we = 1'b1; b_waddr = BW'(it_idx_r); b_wdata = it_val_r;
          end else res_st_nxt = jiap_pkg::STS_OVERFLOW;
        end
        jiap_pkg::CMD_READ_BYTE: begin
          if (32'(it_idx_r) < BUFFER_BYTES) sts.act = jiap_pkg::ACT_BYTE_RD;
          else res_st_nxt = jiap_pkg::STS_OVERFLOW;
        end
        default: res_st_nxt = jiap_pkg::STS_UNKNOWN;
      endcase
    end

    // Read data of the previous step
    if (pend_r) begin
      case (cmd.op)
        jiap_pkg::ST_LOAD: begin
          b_we = 1'b1; b_waddr = pidx_r; b_wdata = f_q;
        end
        jiap_pkg::ST_STORE: begin
          f_we = 1'b1;
          f_waddr = AW'(base_r + RAW'(pidx_r));
          f_wdata = f_q & b_eff;
          if ((f_q & b_eff) != b_eff) res_st_nxt = jiap_pkg::STS_NOT_ERASED;
        end
        jiap_pkg::ST_SEARCH: begin
          if (!found_r && (srch_mask != 8'h00)) begin
            found_nxt = 1'b1;
            pos_nxt = {pidx_r, srch_bit};
          end
        end
        jiap_pkg::ST_UC_RD: begin
          uc_nxt[{pidx_r[1:0], 3'b000} +: 8] = uc_r[{pidx_r[1:0], 3'b000} +: 8] & b_eff;
        end
        jiap_pkg::ST_BYTE_RD: res_rd_nxt = b_eff;
        default: ;
      endcase
    end

    // Issue the next step
    if (issue) begin
      cnt_nxt  = cnt_r + 1'b1;
      pend_nxt = reads;
      pidx_nxt = cnt_r[BW-1:0];
      case (cmd.op)
        jiap_pkg::ST_INIT, jiap_pkg::ST_ERASE: begin
          f_we = 1'b1; f_waddr = cnt_r[AW-1:0]; f_wdata = 8'hFF;
        end
        jiap_pkg::ST_ID_WR: begin
          b_we = 1'b1;
          b_wdata = jiap_pkg::rev8(id_code_r[{~cnt_r[1:0], 3'b000} +: 8]);
        end
        jiap_pkg::ST_UC_WR: begin
          b_we = 1'b1;
          b_wdata = uc_r[{cnt_r[1:0], 3'b000} +: 8];
        end
        jiap_pkg::ST_BYTE_RD: b_raddr = BW'(it_idx_r);
        default: ;
      endcase
    end

    // Address from the one-hot search
    if (cmd.op == jiap_pkg::ST_SCALE) begin
      if (found_r) begin
        ra_nxt = RAW'(prod); wa_nxt = RAW'(prod);
      end else res_st_nxt = jiap_pkg::STS_BAD_ADDR;
    end

    if (b_we) vld_nxt[b_waddr] = 1'b1;
    bv_q_nxt = vld_r[b_raddr];

    if (cmd.load_out) out_data_nxt = {1'b0, res_st_r, res_len_r, res_rd_r};
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= jiap_pkg::DATA_BITS_RST;
      addr_bits_r <= jiap_pkg::ADDR_BITS_RST;
      bound_bits_r <= jiap_pkg::BOUNDARY_BITS_RST;
      id_code_r <= jiap_pkg::ID_CODE_RST;
      array_bytes_r <= jiap_pkg::ARRAY_BYTES_RST;
      ir_r <= 8'h00; isp_r <= 1'b0; pp_r <= 1'b0; rp_r <= 1'b0;
      ra_r <= '0; wa_r <= '0; uc_r <= '1;
      cnt_r <= '0; pend_r <= 1'b0; found_r <= 1'b0; vld_r <= '0;
    end else begin
      data_bits_r <= data_bits_nxt;
      addr_bits_r <= addr_bits_nxt;
      bound_bits_r <= bound_bits_nxt;
      id_code_r <= id_code_nxt;
      array_bytes_r <= array_bytes_nxt;
      ir_r <= ir_nxt; isp_r <= isp_nxt; pp_r <= pp_nxt; rp_r <= rp_nxt;
      ra_r <= ra_nxt; wa_r <= wa_nxt; uc_r <= uc_nxt;
      cnt_r <= cnt_nxt; pend_r <= pend_nxt; found_r <= found_nxt; vld_r <= vld_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    it_cmd_r <= it_cmd_nxt; it_instr_r <= it_instr_nxt;
    it_idx_r <= it_idx_nxt; it_val_r <= it_val_nxt;
    base_r <= base_nxt; pidx_r <= pidx_nxt; pos_r <= pos_nxt; bv_q_r <= bv_q_nxt;
    res_rd_r <= res_rd_nxt; res_len_r <= res_len_nxt; res_st_r <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata = out_data_r;

  // Data shift buffer
  jiap_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_q)
  );

  // Fuse array
  jiap_ram #(.WIDTH(8), .DEPTH(ARRAY_DEPTH)) u_fuse (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_q)
  );

endmodule

/* sv/jtag_isc_array_programmer_top.sv */
// JTAG ISP array programmer: TAP events and buffer byte accesses, one result each.
// Row read or program steps through the row bytes, an address shift update through up
// to the address bytes, and erase through the array bytes; one memory step per cycle on
// the fuse array and shift buffer ports. One item at a time; a stalled result holds off
// the next item.
// Reset (rst_n low, synchronous) clears control state; then a clearing pass fills the
// fuse array with ones before the first item is taken.
module jtag_isc_array_programmer_top #(
  parameter int ARRAY_DEPTH  = jiap_pkg::ARRAY_DEPTH_DEF,
  parameter int BUFFER_BYTES = jiap_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // instruction, byte_index, byte_value
  input  logic [2:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_byte, register_length, status, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  jiap_pkg::jiap_cmd_t cmd;
  jiap_pkg::jiap_sts_t sts;

  assign cfg_ready = 1'b1;

  jiap_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .cmd(cmd)
  );

  jiap_dp #(.ARRAY_DEPTH(ARRAY_DEPTH), .BUFFER_BYTES(BUFFER_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .out_tdata(out_tdata)
  );

  // An accepted item blocks the input until its result is produced
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  // Loading the result register raises the output valid
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result loaded but not presented");

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

/* bench/tb_jtag_isc_array_programmer_top.sv */
// Self-checking testbench for the JTAG ISP array programmer top level.
`timescale 1ns / 1ps

module tb_jtag_isc_array_programmer_top;

  localparam int ARR_DEPTH   = 32768;
  localparam int BUF_BYTES   = 256;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  jtag_isc_array_programmer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result fields, read_byte in the lowest bits
  typedef struct packed {
    logic [2:0]  st;
    logic [11:0] len;
    logic [7:0]  rd;
  } tap_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [7:0]  instr;
    logic [7:0]  idx;
    logic [7:0]  val;
    bit          typed;
    tap_result_t res;
  } stim_row_t;

  // Mirror of the programmer state
  logic [11:0] m_data_bits, m_addr_bits, m_bnd_bits;
  logic [31:0] m_id_code;
  logic [15:0] m_arr_bytes;
  logic [7:0]  m_ir;
  logic [7:0]  m_buf [BUF_BYTES];
  logic [7:0]  m_fuse [ARR_DEPTH];
  logic [31:0] m_ucode;
  int unsigned m_raddr, m_waddr;
  bit          m_isp, m_prog_pend, m_read_pend;

  tap_result_t pending_results[$];
  stim_row_t   dir_rows[$];
  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_prog = 0, n_load = 0, n_erase = 0;
  int  cycles = 0;
  bit  quiet = 0;

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_jtag_isc_array_programmer_top: FAIL");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // Result checker
  always @(posedge clk) begin
    tap_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[22:0];
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.rd !== want.rd || got.len !== want.len || got.st !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: rd %h/%h len %0d/%0d st %0d/%0d (exp/act)",
                     want.rd, got.rd, want.len, got.len, want.st, got.st);
        end
      end
    end
  end

  function automatic int unsigned row_len();
    int unsigned n;
    n = (int'(m_data_bits) + 7) / 8;
    return (n > BUF_BYTES) ? BUF_BYTES : n;
  endfunction

  function automatic int unsigned arr_used();
    return (m_arr_bytes > ARR_DEPTH) ? ARR_DEPTH : m_arr_bytes;
  endfunction

  function automatic logic [7:0] flip8(logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = b[k];
    return r;
  endfunction

  function automatic logic [2:0] fetch_row();
    int unsigned n;
    n = row_len();
    if (m_raddr + n > arr_used()) return jiap_pkg::STS_OVERFLOW;
    for (int i = 0; i < n; i++) m_buf[i] = m_fuse[m_raddr + i];
    m_raddr += n;
    n_load++;
    return jiap_pkg::STS_OK;
  endfunction

  function automatic logic [2:0] burn_row();
    int unsigned n;
    logic [2:0] s;
    logic [7:0] v;
    n = row_len();
    s = jiap_pkg::STS_OK;
    if (m_waddr + n > arr_used()) return jiap_pkg::STS_OVERFLOW;
    for (int i = 0; i < n; i++) begin
      v = m_fuse[m_waddr + i] & m_buf[i];
      m_fuse[m_waddr + i] = v;
      if (v != m_buf[i]) s = jiap_pkg::STS_NOT_ERASED;
    end
    m_waddr += n;
    n_prog++;
    return s;
  endfunction

  // Expected result of one TAP item; updates the mirror
  function automatic tap_result_t tap_predict(logic [2:0] cmd, logic [7:0] instr,
                                              logic [7:0] idx, logic [7:0] val);
    tap_result_t r;
    int unsigned lim, i;
    r = '0;
    case (cmd)
      jiap_pkg::CMD_CAPTURE_IR: begin
        m_ir = jiap_pkg::OP_IR_CAPTURE;
        r.rd = jiap_pkg::OP_IR_CAPTURE;
        r.len = 12'd8;
      end
      jiap_pkg::CMD_UPDATE_IR: begin
        m_ir = instr;
        case (instr)
          jiap_pkg::OP_ERASE: begin
            if (!m_isp) r.st = jiap_pkg::STS_NOT_ISP;
            else begin
              for (int k = 0; k < arr_used(); k++) m_fuse[k] = 8'hFF;
              m_ucode = '1;
              n_erase++;
            end
          end
          jiap_pkg::OP_ENABLE: begin
            m_isp = 1;
            m_read_pend = 0;
            m_prog_pend = 0;
          end
          jiap_pkg::OP_DISABLE: m_isp = 0;
          jiap_pkg::OP_ADDR_INIT: begin
            m_raddr = 0;
            m_waddr = 0;
          end
          jiap_pkg::OP_PROGRAM: m_prog_pend = 1;
          jiap_pkg::OP_READ: m_read_pend = 1;
          default: ;
        endcase
      end
      jiap_pkg::CMD_CAPTURE_DR: begin
        case (m_ir)
          jiap_pkg::OP_ADDR_SHIFT: r.len = m_addr_bits;
          jiap_pkg::OP_IDCODE: begin
            r.len = 12'd32;
            for (int k = 0; k < 4; k++) m_buf[k] = flip8(m_id_code[31 - 8*k -: 8]);
          end
          jiap_pkg::OP_USER_PROG: r.len = 12'd32;
          jiap_pkg::OP_USERCODE: begin
            r.len = 12'd32;
            for (int k = 0; k < 4; k++) m_buf[k] = m_ucode[8*k +: 8];
          end
          jiap_pkg::OP_SAMPLE: begin
            r.len = m_bnd_bits;
            for (int k = 0; k < BUF_BYTES; k++) m_buf[k] = 8'h00;
          end
          jiap_pkg::OP_PROGRAM: begin
            r.len = m_data_bits;
            if (m_read_pend) begin
              r.st = fetch_row();
              m_read_pend = 0;
            end
          end
          jiap_pkg::OP_READ: begin
            r.len = m_data_bits;
            m_read_pend = 0;
            if (!m_prog_pend) r.st = fetch_row();
          end
          jiap_pkg::OP_BYPASS: r.len = 12'd1;
          default: r.st = jiap_pkg::STS_UNKNOWN;
        endcase
      end
      jiap_pkg::CMD_UPDATE_DR: begin
        case (m_ir)
          jiap_pkg::OP_ADDR_SHIFT: begin
            lim = (m_addr_bits > BUF_BYTES * 8) ? BUF_BYTES * 8 : m_addr_bits;
            for (i = 0; i < lim; i++) if (m_buf[i >> 3][i & 7]) break;
            if (i >= lim) r.st = jiap_pkg::STS_BAD_ADDR;
            else begin
              m_raddr = i * row_len();
              m_waddr = m_raddr;
            end
          end
          jiap_pkg::OP_READ: begin
            if (!m_isp) r.st = jiap_pkg::STS_NOT_ISP;
            else if (m_prog_pend) begin
              r.st = burn_row();
              m_prog_pend = 0;
            end
          end
          jiap_pkg::OP_PROGRAM: begin
            if (!m_isp) r.st = jiap_pkg::STS_NOT_ISP;
            else begin
              r.st = burn_row();
              m_prog_pend = 0;
            end
          end
          jiap_pkg::OP_USER_PROG: begin
            if (!m_isp) r.st = jiap_pkg::STS_NOT_ISP;
            else for (int k = 0; k < 4; k++) m_ucode[8*k +: 8] &= m_buf[k];
          end
          default: ;
        endcase
      end
      jiap_pkg::CMD_WRITE_BYTE: m_buf[idx] = val;
      jiap_pkg::CMD_READ_BYTE: r.rd = m_buf[idx];
      default: r.st = jiap_pkg::STS_UNKNOWN;
    endcase
    return r;
  endfunction

  // Present one item; called at a falling edge, returns at a falling edge
  task automatic send_item(logic [2:0] cmd, logic [7:0] instr, logic [7:0] idx,
                           logic [7:0] val, bit typed = 0, tap_result_t res = '0);
    tap_result_t p;
    if (!quiet && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {val, idx, instr};
    do @(posedge clk); while (!in_tready);
    p = tap_predict(cmd, instr, idx, val);
    pending_results.push_back(typed ? res : p);
    n_items++;
    @(negedge clk);
  endtask

  // Hold the sender until every result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // One register write; the caller drops cfg_valid after the last one
  task automatic write_reg(jiap_pkg::jiap_cfg_idx_t ri, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (ri)
      jiap_pkg::CFG_DATA_BITS:     m_data_bits = v[11:0];
      jiap_pkg::CFG_ADDR_BITS:     m_addr_bits = v[11:0];
      jiap_pkg::CFG_BOUNDARY_BITS: m_bnd_bits  = v[11:0];
      jiap_pkg::CFG_ID_CODE:       m_id_code   = v;
      jiap_pkg::CFG_ARRAY_BYTES:   m_arr_bytes = v[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic add_row(logic [2:0] cmd, logic [7:0] instr, logic [7:0] idx,
                         logic [7:0] val, bit typed, logic [7:0] rd, logic [11:0] len,
                         logic [2:0] st);
    stim_row_t row;
    row.cmd = cmd; row.instr = instr; row.idx = idx; row.val = val;
    row.typed = typed; row.res = '{rd: rd, len: len, st: st};
    dir_rows.push_back(row);
  endtask

  // One random sequence; mostly well-formed TAP flows with random content
  task automatic random_flow();
    int kind, nb, pos;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 22) begin
      // row program
      if ($urandom_range(3) == 0) send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ENABLE, 0, 0);
      send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_PROGRAM, 0, 0);
      send_item(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0);
      nb = row_len();
      repeat ($urandom_range(1, 6)) begin
        b = ($urandom_range(2) == 0) ? 8'hFF : 8'($urandom);
        send_item(jiap_pkg::CMD_WRITE_BYTE, 8'($urandom), 8'($urandom_range(nb - 1)), b);
      end
      send_item(jiap_pkg::CMD_UPDATE_DR, 8'($urandom), 0, 0);
    end else if (kind < 40) begin
      // row read
      send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_READ, 0, 0);
      send_item(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0);
      nb = row_len();
      repeat ($urandom_range(1, 5))
        send_item(jiap_pkg::CMD_READ_BYTE, 0, 8'($urandom_range(nb - 1)), 8'($urandom));
      send_item(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0);
    end else if (kind < 52) begin
      // one-hot address, sometimes out of range or empty
      send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ADDR_SHIFT, 0, 0);
      send_item(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0);
      pos = $urandom_range((m_addr_bits > 64) ? 63 : int'(m_addr_bits) + 8);
      for (int k = 0; k <= pos / 8; k++) begin
        b = (k == pos / 8) ? (8'h01 << (pos % 8)) : 8'h00;
        if ($urandom_range(9) == 0) b = 8'h00;
        send_item(jiap_pkg::CMD_WRITE_BYTE, 0, 8'(k), b);
      end
      send_item(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0);
    end else if (kind < 58) begin
      send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ADDR_INIT, 0, 0);
    end else if (kind < 66) begin
      // usercode program then read back
      send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_USER_PROG, 0, 0);
      send_item(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0);
      for (int k = 0; k < 4; k++)
        send_item(jiap_pkg::CMD_WRITE_BYTE, 0, 8'(k), 8'($urandom));
      send_item(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0);
      send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_USERCODE, 0, 0);
      send_item(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0);
      send_item(jiap_pkg::CMD_READ_BYTE, 0, 8'($urandom_range(3)), 0);
    end else if (kind < 72) begin
      // idcode, sample, bypass captures
      case ($urandom_range(2))
        0: send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_IDCODE, 0, 0);
        1: send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_SAMPLE, 0, 0);
        default: send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_BYPASS, 0, 0);
      endcase
      send_item(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0);
      send_item(jiap_pkg::CMD_READ_BYTE, 0, 8'($urandom_range(3)), 0);
      send_item(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0);
    end else if (kind < 76) begin
      send_item(jiap_pkg::CMD_UPDATE_IR,
                ($urandom_range(2) == 0) ? jiap_pkg::OP_DISABLE : jiap_pkg::OP_ENABLE,
                0, 0);
    end else if (kind < 78) begin
      // erase, cheap only on small arrays
      if (m_arr_bytes <= 4096 || $urandom_range(3) == 0) begin
        send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ENABLE, 0, 0);
        send_item(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ERASE, 0, 0);
      end
    end else begin
      // noise across every field and command code
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom);
        if (b == jiap_pkg::OP_ERASE && m_arr_bytes > 4096) b = jiap_pkg::OP_BYPASS;
        send_item(3'($urandom_range(7)), b, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [31:0] knob [5];
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    out_tready = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    rst_n = 0;
    m_data_bits = jiap_pkg::DATA_BITS_RST;
    m_addr_bits = jiap_pkg::ADDR_BITS_RST;
    m_bnd_bits = jiap_pkg::BOUNDARY_BITS_RST;
    m_id_code = jiap_pkg::ID_CODE_RST;
    m_arr_bytes = jiap_pkg::ARRAY_BYTES_RST;
    m_ir = '0; m_ucode = '1; m_raddr = 0; m_waddr = 0;
    m_isp = 0; m_prog_pend = 0; m_read_pend = 0;
    for (int k = 0; k < BUF_BYTES; k++) m_buf[k] = 8'h00;
    for (int k = 0; k < ARR_DEPTH; k++) m_fuse[k] = 8'hFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed table at reset settings
    add_row(jiap_pkg::CMD_CAPTURE_IR, 0, 0, 0, 1, jiap_pkg::OP_IR_CAPTURE, 8,
            jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0, 1, 0, 0, jiap_pkg::STS_UNKNOWN);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_BYPASS, 0, 0, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0, 1, 0, 1, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_IDCODE, 0, 0, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0, 1, 0, 32, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_READ_BYTE, 0, 0, 0, 0, 0, 0, 0);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ERASE, 0, 0, 1, 0, 0,
            jiap_pkg::STS_NOT_ISP);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_PROGRAM, 0, 0, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0, 1, 0, 0, jiap_pkg::STS_NOT_ISP);
    add_row(CMD_SPARE_6, 8'hFF, 8'hFF, 8'hFF, 1, 0, 0, jiap_pkg::STS_UNKNOWN);
    add_row(CMD_SPARE_7, 0, 0, 0, 1, 0, 0, jiap_pkg::STS_UNKNOWN);
    add_row(jiap_pkg::CMD_WRITE_BYTE, 0, 8'hFF, 8'hFF, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_READ_BYTE, 0, 8'hFF, 0, 1, 8'hFF, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ADDR_SHIFT, 0, 0, 1, 0, 0,
            jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0, 1, 0, 100, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0, 0, 0, 0, 0);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ENABLE, 0, 0, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_ADDR_INIT, 0, 0, 1, 0, 0,
            jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_PROGRAM, 0, 0, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_WRITE_BYTE, 0, 0, 8'h00, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0, 0, 0, 0, 0);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_READ, 0, 0, 1, 0, 0, jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_CAPTURE_DR, 0, 0, 0, 0, 0, 0, 0);
    add_row(jiap_pkg::CMD_READ_BYTE, 0, 1, 0, 0, 0, 0, 0);
    add_row(jiap_pkg::CMD_UPDATE_IR, jiap_pkg::OP_USER_PROG, 0, 0, 1, 0, 0,
            jiap_pkg::STS_OK);
    add_row(jiap_pkg::CMD_UPDATE_DR, 0, 0, 0, 0, 0, 0, 0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].instr, dir_rows[i].idx, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].res);
    drain();

    // Random phases over several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: knob = '{32'd1, 32'd1, 32'd1, 32'h0000_0000, 32'd1};
        1: knob = '{32'd64, 32'd24, 32'd40, 32'hA5C3_0F96, 32'd512};
        2: knob = '{32'd2048, 32'd2048, 32'd2048, 32'hFFFF_FFFF, 32'd32768};
        3: knob = '{32'd17, 32'd9, 32'd300, 32'($urandom), 32'd200};
        default: knob = '{32'($urandom_range(1, 96)), 32'($urandom_range(1, 80)),
                          32'($urandom_range(1, 2048)), 32'($urandom),
                          32'($urandom_range(64, 4096))};
      endcase
      write_reg(jiap_pkg::CFG_DATA_BITS, knob[0]);
      write_reg(jiap_pkg::CFG_ADDR_BITS, knob[1]);
      write_reg(jiap_pkg::CFG_BOUNDARY_BITS, knob[2]);
      write_reg(jiap_pkg::CFG_ID_CODE, knob[3]);
      write_reg(jiap_pkg::CFG_ARRAY_BYTES, knob[4]);
      cfg_valid <= 1'b0;
      quiet = (ph == 1);
      for (int target = n_items + 275; n_items < target; ) begin
        random_flow();
        if ($urandom_range(49) == 0) drain();
      end
      quiet = 0;
      drain();
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d items and %0d results over six register settings", n_items,
             n_results);
    $display("rows programmed %0d, rows loaded %0d, erases %0d", n_prog, n_load, n_erase);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_jtag_isc_array_programmer_top: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_jtag_isc_array_programmer_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/jiap_pkg.sv
sv/jiap_ram.sv
sv/jiap_ctrl.sv
sv/jiap_dp.sv
sv/jtag_isc_array_programmer_top.sv
bench/tb_jtag_isc_array_programmer_top.sv
